/* rtl/srp_pkg.sv */
// Shared types, codes and default sizes of the scan-line run-length profile block.
package srp_pkg;

   // Default sizes, handed to the top level's parameters
   localparam int MAX_LINE_LENGTH_DEF = 4096;
   localparam int MAX_LINES_DEF       = 4096;
   localparam int FRACTION_BITS_DEF   = 8;

   // Fixed field widths
   localparam int PIX_W   = 8;
   localparam int OUT_W   = 28;
   localparam int IDX_W   = 12;
   localparam int MODE_W  = 2;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 8;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   // Register indexes of the configuration port
   localparam logic [CSR_A_W-1:0] CSR_TARGET_VALUE = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_PROFILE_MODE = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_NORMALIZE    = 2'd2;

   // Profile modes; the unused code falls back to the pixel sum
   localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0]  target_value;
      logic [MODE_W-1:0] profile_mode;
      logic              normalize;
   } srp_cfg_type;

   typedef enum logic [1:0] {
      SRP_ACCUM,
      SRP_SETUP,
      SRP_DIVIDE,
      SRP_FINISH
   } srp_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // pixel transaction taken this cycle
      logic capture;  // line end: snapshot operands, clear statistics
      logic mult;     // form the divisor
      logic step;     // one quotient bit
      logic load;     // move the quotient into the result register
   } srp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_last; // this step yields the final quotient bit
      logic out_free; // result register can take a new value
   } srp_status_type;

endpackage

/* rtl/scanline_runlength_profile.sv */
// Top level of the scan-line run-length profile block: registers, controller and datapath.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | pixel, end_of_line, end_of_frame
//   rsp_    | out       | rsp_valid/rsp_stall | profile_value, line_index
//   csr_    | in        | csr_valid/csr_ready | index, wdata
//
// Pixels are taken one per cycle while the input is not stalled. A pixel carrying a line or
// frame end stalls the input while the setup state forms the divisor, the bit-serial
// restoring divider runs, and the finish state hands the quotient to the result register;
// that last state stretches while a previous result still waits on rsp_stall.
// Reset is synchronous and active high; it clears the statistics, the line counter,
// the registers and the result valid. The configuration port is always ready.
module scanline_runlength_profile #(
   parameter int MAX_LINE_LENGTH = srp_pkg::MAX_LINE_LENGTH_DEF,
   parameter int MAX_LINES       = srp_pkg::MAX_LINES_DEF,
   parameter int FRACTION_BITS   = srp_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel stream
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srp_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          req_end_of_line,
   input  logic                          req_end_of_frame,
   // line results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srp_pkg::OUT_W-1:0]     rsp_profile_value,
   output logic [srp_pkg::IDX_W-1:0]     rsp_line_index,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srp_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [srp_pkg::CSR_D_W-1:0]   csr_wdata
);

   srp_pkg::srp_cfg_type    cfg_ff;
   srp_pkg::srp_cmd_type    cmd;
   srp_pkg::srp_status_type status;

   assign csr_ready = 1'b1;

   // Register file: mask each write to its register's width, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srp_pkg::CSR_TARGET_VALUE: cfg_ff.target_value <= csr_wdata;
            srp_pkg::CSR_PROFILE_MODE: cfg_ff.profile_mode <= csr_wdata[srp_pkg::MODE_W-1:0];
            srp_pkg::CSR_NORMALIZE:    cfg_ff.normalize    <= csr_wdata[0];
            default:                   cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // Sequence the line-end work: accumulate, set up divisor, divide, deliver
   srp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_line  (req_end_of_line),
      .req_end_of_frame (req_end_of_frame),
      .req_stall        (req_stall),
      .status           (status),
      .cmd              (cmd)
   );

   // Hold the statistics and perform the division
   srp_dpath #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
      .MAX_LINES       (MAX_LINES),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .status            (status),
      .req_pixel         (req_pixel),
      .req_end_of_frame  (req_end_of_frame),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_profile_value (rsp_profile_value),
      .rsp_line_index    (rsp_line_index)
   );

`ifndef ASSERT_OFF
   // A line-end transaction must start the divide sequence and hold off input
   a_line_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_end_of_line || req_end_of_frame)) |=> req_stall)
      else $error("input not stalled after line end");

   // A new result only appears out of the divide sequence
   a_result_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared outside divide sequence");

   // Loading the result register never overwrites an undelivered result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result register overwritten");
`endif

endmodule

/* rtl/srp_ctrl.sv */
// Controller state machine of the scan-line run-length profile block.
module srp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_end_of_line,
   input  logic                    req_end_of_frame,
   output logic                    req_stall,
   input  srp_pkg::srp_status_type status,
   output srp_pkg::srp_cmd_type    cmd
);

   srp_pkg::srp_state_type state_ff;
   srp_pkg::srp_state_type state_in;
   logic                   accept;
   logic                   line_end;

   assign accept   = req_valid && !req_stall;
   assign line_end = accept && (req_end_of_line || req_end_of_frame);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srp_pkg::SRP_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srp_pkg::SRP_ACCUM: begin
            if (line_end) state_in = srp_pkg::SRP_SETUP;
         end
         srp_pkg::SRP_SETUP: begin
            state_in = srp_pkg::SRP_DIVIDE;
         end
         srp_pkg::SRP_DIVIDE: begin
            if (status.div_last) state_in = srp_pkg::SRP_FINISH;
         end
         srp_pkg::SRP_FINISH: begin
            if (status.out_free) state_in = srp_pkg::SRP_ACCUM;
         end
         default: begin
            state_in = srp_pkg::SRP_ACCUM;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd         = '0;
      cmd.accept  = accept;
      cmd.capture = line_end;
      case (state_ff)
         srp_pkg::SRP_ACCUM: begin
            req_stall = 1'b0;
         end
         srp_pkg::SRP_SETUP: begin
            cmd.mult = 1'b1;
         end
         srp_pkg::SRP_DIVIDE: begin
            cmd.step = 1'b1;
         end
         srp_pkg::SRP_FINISH: begin
            cmd.load = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/srp_dpath.sv */
// Datapath: line statistics, line counter, divisor, bit-serial divider and result register.
module srp_dpath #(
   parameter int MAX_LINE_LENGTH = srp_pkg::MAX_LINE_LENGTH_DEF,
   parameter int MAX_LINES       = srp_pkg::MAX_LINES_DEF,
   parameter int FRACTION_BITS   = srp_pkg::FRACTION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  srp_pkg::srp_cfg_type        cfg,
   input  srp_pkg::srp_cmd_type        cmd,
   output srp_pkg::srp_status_type     status,
   input  logic [srp_pkg::PIX_W-1:0]   req_pixel,
   input  logic                        req_end_of_frame,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [srp_pkg::OUT_W-1:0]   rsp_profile_value,
   output logic [srp_pkg::IDX_W-1:0]   rsp_line_index
);

   localparam int LEN_W  = $clog2(MAX_LINE_LENGTH + 1);
   localparam int RUN_W  = $clog2((MAX_LINE_LENGTH + 1) / 2 + 1);
   localparam int SUM_W  = $clog2(MAX_LINE_LENGTH * 255 + 1);
   localparam int VAL_W  = (SUM_W > LEN_W) ? SUM_W : LEN_W;
   localparam int NUM_W  = VAL_W + FRACTION_BITS;
   localparam int DEN_W  = RUN_W + LEN_W;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int QX_W   = (NUM_W > srp_pkg::OUT_W) ? NUM_W : srp_pkg::OUT_W;

   // Line statistics
   logic [LEN_W-1:0] current_run_ff, current_run_in;
   logic [LEN_W-1:0] longest_run_ff, longest_run_in;
   logic [LEN_W-1:0] match_total_ff, match_total_in;
   logic [RUN_W-1:0] run_total_ff, run_total_in;
   logic [SUM_W-1:0] pixel_sum_ff, pixel_sum_in;
   logic [LEN_W-1:0] pixels_seen_ff, pixels_seen_in;
   logic [LINE_W-1:0] line_counter_ff, line_counter_in;
   logic             in_range;
   logic             hit;

   always_comb begin
      in_range       = pixels_seen_ff < LEN_W'(MAX_LINE_LENGTH);
      hit            = req_pixel == cfg.target_value;
      current_run_in = current_run_ff;
      longest_run_in = longest_run_ff;
      match_total_in = match_total_ff;
      run_total_in   = run_total_ff;
      pixel_sum_in   = pixel_sum_ff;
      pixels_seen_in = pixels_seen_ff;
      if (cmd.accept && in_range) begin
         pixels_seen_in = pixels_seen_ff + LEN_W'(1);
         pixel_sum_in   = pixel_sum_ff + SUM_W'(req_pixel);
         if (hit) begin
            if (current_run_ff == '0) run_total_in = run_total_ff + RUN_W'(1);
            current_run_in = current_run_ff + LEN_W'(1);
            match_total_in = match_total_ff + LEN_W'(1);
            if (current_run_in > longest_run_ff) longest_run_in = current_run_in;
         end else begin
            current_run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         current_run_ff <= '0;
         longest_run_ff <= '0;
         match_total_ff <= '0;
         run_total_ff   <= '0;
         pixel_sum_ff   <= '0;
         pixels_seen_ff <= '0;
      end else begin
         current_run_ff <= current_run_in;
         longest_run_ff <= longest_run_in;
         match_total_ff <= match_total_in;
         run_total_ff   <= run_total_in;
         pixel_sum_ff   <= pixel_sum_in;
         pixels_seen_ff <= pixels_seen_in;
      end
   end

   // Line counter: wrap at the frame end or after the last line number
   always_comb begin
      line_counter_in = line_counter_ff;
      if (cmd.capture) begin
         if (req_end_of_frame ||
             (32'(line_counter_ff) + 32'd1 >= 32'(MAX_LINES))) begin
            line_counter_in = '0;
         end else begin
            line_counter_in = line_counter_ff + LINE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_counter_ff <= '0;
      end else begin
         line_counter_ff <= line_counter_in;
      end
   end

   // Operand snapshot at the line end
   logic [VAL_W-1:0]         value_sel;
   logic [RUN_W-1:0]         fact_a_in, fact_a_ff;
   logic [LEN_W-1:0]         fact_b_in, fact_b_ff;
   logic [31:0]              line_wide;
   logic [srp_pkg::IDX_W-1:0] index_ff;
   logic [DEN_W-1:0]         den_ff;

   always_comb begin
      case (cfg.profile_mode)
         srp_pkg::MODE_MAX: value_sel = VAL_W'(longest_run_in);
         srp_pkg::MODE_AVG: value_sel = VAL_W'(match_total_in);
         default:           value_sel = VAL_W'(pixel_sum_in);
      endcase
      fact_a_in = RUN_W'(1);
      if (cfg.profile_mode == srp_pkg::MODE_AVG && run_total_in != '0) begin
         fact_a_in = run_total_in;
      end
      fact_b_in = LEN_W'(1);
      if (cfg.normalize && pixels_seen_in != '0) fact_b_in = pixels_seen_in;
      line_wide = 32'(line_counter_ff);
   end

   // Restoring divider, one quotient bit per step
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - (DEN_W + 1)'(den_ff);
      ge     = trial >= (DEN_W + 1)'(den_ff);
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         fact_a_ff <= fact_a_in;
         fact_b_ff <= fact_b_in;
         index_ff  <= line_wide[srp_pkg::IDX_W-1:0];
         quo_ff    <= NUM_W'(value_sel) << FRACTION_BITS;
         rem_ff    <= '0;
      end else if (cmd.step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.mult) den_ff <= DEN_W'(fact_a_ff * fact_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Result register with saturation
   logic                      rsp_valid_ff;
   logic [srp_pkg::OUT_W-1:0] value_ff;
   logic [srp_pkg::IDX_W-1:0] out_index_ff;
   logic [QX_W-1:0]           quo_wide;
   logic [srp_pkg::OUT_W-1:0] value_sat;

   always_comb begin
      quo_wide  = QX_W'(quo_ff);
      value_sat = (quo_wide > QX_W'(srp_pkg::OUT_MAX)) ? srp_pkg::OUT_MAX
                                                       : quo_wide[srp_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         value_ff     <= value_sat;
         out_index_ff <= index_ff;
      end
   end

   assign status.div_last   = cnt_ff == CNT_W'(NUM_W - 1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_profile_value = value_ff;
   assign rsp_line_index    = out_index_ff;

endmodule

/* tb/tb_scanline_runlength_profile.sv */
// Self-checking testbench for the scan-line run-length profile block.
`timescale 1ns / 100ps

module tb_scanline_runlength_profile;

   // Cycles without any transaction before the run is abandoned
   localparam int WATCHDOG_LIMIT = 3000;
   // Cycles to let the divider drain before touching the registers or ending
   localparam int SETTLE_CYCLES  = 40;
   // Register index with no register behind it
   localparam logic [srp_pkg::CSR_A_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [srp_pkg::OUT_W-1:0] profile_value;
      logic [srp_pkg::IDX_W-1:0] line_index;
   } line_result_type;

   // Line statistics predictor and store of awaited line results
   class line_profile_board_type;
      bit [srp_pkg::PIX_W-1:0]   tgt;
      bit [srp_pkg::MODE_W-1:0]  mode;
      bit                        norm;
      bit [12:0]                 run_len;
      bit [12:0]                 best_run;
      bit [12:0]                 hit_count;
      bit [11:0]                 run_count;
      bit [19:0]                 sum_acc;
      bit [12:0]                 pix_count;
      bit [srp_pkg::IDX_W-1:0]   line_no;
      line_result_type           awaited[$];
      int                        errors;

      function void write_register(bit [srp_pkg::CSR_A_W-1:0] idx,
                                   bit [srp_pkg::CSR_D_W-1:0] data);
         case (idx)
            srp_pkg::CSR_TARGET_VALUE: tgt  = data;
            srp_pkg::CSR_PROFILE_MODE: mode = data[srp_pkg::MODE_W-1:0];
            srp_pkg::CSR_NORMALIZE:    norm = data[0];
            default: ;
         endcase
      endfunction

      function void note_pixel(bit [srp_pkg::PIX_W-1:0] pix, bit eol, bit eof);
         longint unsigned num;
         longint unsigned den;
         longint unsigned quo;
         line_result_type res;
         // pixels past the line limit count for nothing, only their flags act
         if (pix_count < srp_pkg::MAX_LINE_LENGTH_DEF) begin
            pix_count++;
            sum_acc += pix;
            if (pix == tgt) begin
               if (run_len == 0)
                  run_count++;
               run_len++;
               hit_count++;
               if (run_len > best_run)
                  best_run = run_len;
            end else begin
               run_len = 0;
            end
         end
         if (!eol && !eof)
            return;
         den = 1;
         case (mode)
            srp_pkg::MODE_MAX: num = best_run;
            srp_pkg::MODE_AVG: begin
               num = hit_count;
               if (run_count != 0)
                  den = run_count;
            end
            default:  num = sum_acc;   // the spare mode code falls back to the sum
         endcase
         if (norm && pix_count != 0)
            den = den * pix_count;
         quo = (num << srp_pkg::FRACTION_BITS_DEF) / den;
         if (quo > srp_pkg::OUT_MAX)
            quo = srp_pkg::OUT_MAX;
         res.profile_value = quo[srp_pkg::OUT_W-1:0];
         res.line_index    = line_no;
         awaited.push_back(res);
         run_len   = 0;
         best_run  = 0;
         hit_count = 0;
         run_count = 0;
         sum_acc   = 0;
         pix_count = 0;
         if (eof || int'(line_no) + 1 >= srp_pkg::MAX_LINES_DEF)
            line_no = 0;
         else
            line_no++;
      endfunction

      function void check_result(bit [srp_pkg::OUT_W-1:0] value,
                                 bit [srp_pkg::IDX_W-1:0] index);
         line_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected line result, expected none, actual value %0d index %0d",
                     $time, value, index);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (value != want.profile_value) begin
            $display("%0t: profile_value mismatch, expected %0d, actual %0d",
                     $time, want.profile_value, value);
            errors++;
         end
         if (index != want.line_index) begin
            $display("%0t: line_index mismatch, expected %0d, actual %0d",
                     $time, want.line_index, index);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [srp_pkg::PIX_W-1:0]    req_pixel;
   logic                         req_end_of_line;
   logic                         req_end_of_frame;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [srp_pkg::OUT_W-1:0]    rsp_profile_value;
   logic [srp_pkg::IDX_W-1:0]    rsp_line_index;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [srp_pkg::CSR_A_W-1:0]  csr_index;
   logic [srp_pkg::CSR_D_W-1:0]  csr_wdata;

   line_profile_board_type       board;
   bit                           quiet;        // suppress idling on both sides
   int                           idle_cycles = 0;
   int                           stall_left = 0;
   int                           stall_roll;

   scanline_runlength_profile dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_end_of_line   (req_end_of_line),
      .req_end_of_frame  (req_end_of_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_profile_value (rsp_profile_value),
      .rsp_line_index    (rsp_line_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mostly no gap, sometimes a short one, now and then a long one; none while quiet
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Bias pixels towards the target so runs form, and towards the extremes
   function automatic bit [srp_pkg::PIX_W-1:0] pick_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return board.tgt;
      if (roll == 5)
         return '0;
      if (roll == 6)
         return '1;
      return $urandom_range(0, 255);
   endfunction

   // Result side: check accepted transactions, generate the stall pattern, and
   // abandon the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_profile_value, rsp_line_index);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      if (quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 60) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d line results awaited",
                  $time, board.pending());
         $display("tb_scanline_runlength_profile NOT OK");
         $finish;
      end
   end

   // Offer one pixel transaction and hold it until the block takes it.
   // Valid is left high on return so back-to-back pixels need no second assignment.
   task automatic send_pixel(input bit [srp_pkg::PIX_W-1:0] pix, input bit eol,
                             input bit eof);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel        <= pix;
      req_end_of_line  <= eol;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
      board.note_pixel(pix, eol, eof);
   endtask

   // Single register write; valid stays high for the caller to drop
   task automatic csr_write(input bit [srp_pkg::CSR_A_W-1:0] idx,
                            input bit [srp_pkg::CSR_D_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, data);
   endtask

   // Drain the block, then write all three registers (and the spare index if asked)
   task automatic configure(input bit [srp_pkg::CSR_D_W-1:0] tgt_w,
                            input bit [srp_pkg::CSR_D_W-1:0] mode_w,
                            input bit [srp_pkg::CSR_D_W-1:0] norm_w,
                            input bit touch_spare);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(srp_pkg::CSR_TARGET_VALUE, tgt_w);
      csr_write(srp_pkg::CSR_PROFILE_MODE, mode_w);
      csr_write(srp_pkg::CSR_NORMALIZE, norm_w);
      if (touch_spare)
         csr_write(CSR_SPARE, $urandom_range(0, 255));
      csr_valid <= 1'b0;
   endtask

   // Random lines until at least the given number of pixels has gone; always ends
   // on a line end so the next phase starts clean.
   task automatic random_lines(input int items);
      int sent;
      int len;
      int roll;
      bit eol;
      bit eof;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            eol = 1'b0;
            eof = 1'b0;
            if (i == len - 1) begin
               roll = $urandom_range(0, 15);
               // frame end on its own also closes the line
               eol = (roll != 0);
               eof = (roll < 3);
            end
            send_pixel(pick_pixel(), eol, eof);
         end
         sent += len;
      end
   endtask

   initial begin
      bit [srp_pkg::CSR_D_W-1:0] tgt_w;
      bit [srp_pkg::CSR_D_W-1:0] mode_w;
      bit [srp_pkg::CSR_D_W-1:0] norm_w;

      board            = new;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel        = '0;
      req_end_of_line  = 1'b0;
      req_end_of_frame = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      quiet            = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pixel sum, target 0, no normalising.
      // Extremes, a frame end with no line end, and both ends together.
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd0,   1'b1, 1'b0);
      send_pixel(8'd7,   1'b0, 1'b1);
      send_pixel(8'd255, 1'b1, 1'b1);
      send_pixel(8'd0,   1'b1, 1'b0);

      // Longest run; upper mode bits set to check the masking
      configure(8'd255, 8'hFD, 8'h00, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd0,   1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b1, 1'b0);
      send_pixel(8'd1,   1'b0, 1'b0);
      send_pixel(8'd2,   1'b1, 1'b0);

      // Average run, normalised; the second line has no run at all
      configure(8'd0, srp_pkg::MODE_AVG, 8'd1, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd5, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd9, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b1, 1'b0);
      send_pixel(8'd3, 1'b1, 1'b0);

      // Undefined mode code acts as the sum; junk write to the unused index
      configure(8'd128, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'd128, 1'b0, 1'b0);
      send_pixel(8'd127, 1'b1, 1'b1);

      // Random phases walking through every mode and normalise setting
      for (int k = 0; k < 8; k++) begin
         tgt_w  = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         mode_w = $urandom_range(0, 255);
         mode_w[srp_pkg::MODE_W-1:0] = k[1:0];
         norm_w = $urandom_range(0, 255);
         norm_w[0] = k[2] ^ k[0];
         configure(tgt_w, mode_w, norm_w, k == 5);
         quiet = (k == 3);
         random_lines(125);
         quiet = 1'b0;
      end

      // Drop valid, wait for the last results, then give the block time to misbehave
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("tb_scanline_runlength_profile OK");
      else
         $display("tb_scanline_runlength_profile NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
rtl/srp_pkg.sv
rtl/srp_ctrl.sv
rtl/srp_dpath.sv
rtl/scanline_runlength_profile.sv
tb/tb_scanline_runlength_profile.sv
